[sv/tpwe_pkg.sv]
`default_nettype none

package tpwe_pkg;

    localparam int unsigned RUN_W   = 23;
    localparam int unsigned HALF_W  = 17;
    localparam int unsigned DIVD_W  = 18;
    localparam int unsigned DIV_W   = 8;
    localparam int unsigned TS_W    = 16;
    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned M_DATA_W = 40;

    typedef logic [1:0] opcode_t;

    localparam opcode_t OP_DATA    = 2'd0;
    localparam opcode_t OP_PULSE   = 2'd1;
    localparam opcode_t OP_REPEAT  = 2'd2;
    localparam opcode_t OP_SILENCE = 2'd3;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t REG_SAMPLE_DIVISOR = 2'd0;
    localparam cfg_index_t REG_CHANNEL_MODE   = 2'd1;
    localparam cfg_index_t REG_ZERO_PULSE_TS  = 2'd2;
    localparam cfg_index_t REG_ONE_PULSE_TS   = 2'd3;

    localparam logic [1:0] MODE_MONO     = 2'd0;
    localparam logic [1:0] MODE_INVERTED = 2'd2;

    localparam logic [7:0] LEVEL_LOW_BYTE  = 8'hC0;
    localparam logic [7:0] LEVEL_HIGH_BYTE = 8'h40;
    localparam logic [7:0] SILENCE_BYTE    = 8'd128;

    localparam logic [DIV_W-1:0] DIVISOR_RESET = 8'd160;
    localparam logic [TS_W-1:0]  ZERO_TS_RESET = 16'd855;
    localparam logic [TS_W-1:0]  ONE_TS_RESET  = 16'd1710;

endpackage

`default_nettype wire

[sv/tape_pulse_wave_encoder_core.sv]
// tape pulse encoder: one restoring divider step (one quotient bit) per cycle
// a pulse goes from load to output register: load, 18 divide steps, hand-off
// single pulse and repeat items: one pulse each, data byte: 16 pulses
// silence item: no divide step; output register lets the next pulse divide while a run waits
// rst_n is asynchronous active low: registers return to 160 / mono / 855 / 1710,
// remainder, level and last pulse length clear, no run pending
`default_nettype none

module tape_pulse_wave_encoder_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration write port
    input  wire logic                           cfg_we,
    input  wire tpwe_pkg::cfg_index_t           cfg_addr,
    input  wire logic [15:0]                    cfg_data,
    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // data_byte[7:0], pulse_ts[23:8], silence_samples[46:24], zero fill [47]
    input  wire logic [tpwe_pkg::S_DATA_W-1:0]  s_tdata,
    // opcode[1:0]
    input  wire tpwe_pkg::opcode_t              s_tuser,
    // output stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // run_samples[22:0], first_sample[30:23], second_sample[38:31], zero fill [39]
    output logic [tpwe_pkg::M_DATA_W-1:0]       m_tdata,
    // two_channels[0]
    output logic [0:0]                          m_tuser,
    // last_of_item
    output logic                                m_tlast
);
    import tpwe_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic [4:0] LAST_STEP = 5'(DIVD_W - 1);

    logic [1:0]        state_reg, state_next;

    logic [DIV_W-1:0]  divisor_reg;
    logic [1:0]        mode_reg;
    logic [TS_W-1:0]   zero_ts_reg;
    logic [TS_W-1:0]   one_ts_reg;

    logic [DIV_W-1:0]  remainder_reg;
    logic              level_reg;
    logic [HALF_W-1:0] last_half_reg;

    opcode_t           op_reg;
    logic [7:0]        byte_reg;
    logic [TS_W-1:0]   pulse_reg;
    logic [RUN_W-1:0]  silence_reg;
    logic [3:0]        pulse_idx_reg;

    logic [DIVD_W-1:0] quot_reg;
    logic [DIV_W-1:0]  part_reg;
    logic [4:0]        step_reg;

    logic              out_valid_reg;
    logic [RUN_W-1:0]  out_run_reg;
    logic [7:0]        out_first_reg;
    logic [7:0]        out_second_reg;
    logic              out_two_reg;
    logic              out_last_reg;

    logic [DIV_W-1:0]  div_eff;
    logic [DIV_W:0]    trial;
    logic              trial_ge;
    logic [DIV_W:0]    trial_diff;
    logic [DIV_W-1:0]  part_next;
    logic [HALF_W-1:0] half_load;
    logic [TS_W-1:0]   bit_ts;
    logic              out_free;
    logic              two_ch;
    logic [7:0]        cur_byte;
    logic [7:0]        inv_byte;
    logic              emit_last;

    assign div_eff    = (divisor_reg == '0) ? DIV_W'(1) : divisor_reg;
    assign trial      = {part_reg, quot_reg[DIVD_W-1]};
    assign trial_ge   = (trial >= {1'b0, div_eff});
    assign trial_diff = trial - {1'b0, div_eff};
    assign part_next  = trial_ge ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];

    assign bit_ts = byte_reg[7] ? one_ts_reg : zero_ts_reg;

    always_comb
    begin
        unique case (op_reg)
            OP_DATA:  half_load = {bit_ts, 1'b0};
            OP_PULSE: half_load = {pulse_reg, 1'b0};
            default:  half_load = last_half_reg;
        endcase
    end

    assign out_free  = !out_valid_reg || m_tready;
    assign two_ch    = (mode_reg != MODE_MONO);
    assign cur_byte  = level_reg ? LEVEL_HIGH_BYTE : LEVEL_LOW_BYTE;
    assign inv_byte  = level_reg ? LEVEL_LOW_BYTE : LEVEL_HIGH_BYTE;
    assign emit_last = (op_reg != OP_DATA) || (pulse_idx_reg == 4'hF);

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (s_tuser == OP_SILENCE) ? ST_EMIT : ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = emit_last ? ST_IDLE : ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            divisor_reg   <= DIVISOR_RESET;
            mode_reg      <= MODE_MONO;
            zero_ts_reg   <= ZERO_TS_RESET;
            one_ts_reg    <= ONE_TS_RESET;
            remainder_reg <= '0;
            level_reg     <= 1'b0;
            last_half_reg <= '0;
            pulse_idx_reg <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_SAMPLE_DIVISOR: divisor_reg <= cfg_data[DIV_W-1:0];
                    REG_CHANNEL_MODE:   mode_reg    <= cfg_data[1:0];
                    REG_ZERO_PULSE_TS:  zero_ts_reg <= cfg_data;
                    REG_ONE_PULSE_TS:   one_ts_reg  <= cfg_data;
                    default:            ;
                endcase
            end

            // a new run loads as the held one leaves, otherwise hold until taken
            out_valid_reg <= (state_reg == ST_EMIT && out_free) ||
                             (out_valid_reg && !m_tready);

            unique case (state_reg)
                ST_IDLE:
                begin
                    pulse_idx_reg <= '0;
                end
                ST_LOAD:
                begin
                    last_half_reg <= half_load;
                    step_reg      <= '0;
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == LAST_STEP)
                    begin
                        remainder_reg <= part_next;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        if (op_reg == OP_SILENCE)
                        begin
                            remainder_reg <= '0;
                        end
                        else
                        begin
                            level_reg <= ~level_reg;
                        end
                        pulse_idx_reg <= pulse_idx_reg + 4'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // item fields, divider datapath and output payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            op_reg      <= s_tuser;
            byte_reg    <= s_tdata[7:0];
            pulse_reg   <= s_tdata[23:8];
            silence_reg <= s_tdata[46:24];
        end

        if (state_reg == ST_LOAD)
        begin
            quot_reg <= {1'b0, half_load} + {{(DIVD_W-DIV_W){1'b0}}, remainder_reg};
            part_reg <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            quot_reg <= {quot_reg[DIVD_W-2:0], trial_ge};
            part_reg <= part_next;
        end

        if (state_reg == ST_EMIT && out_free)
        begin
            // next data bit after both pulses of this one
            if (pulse_idx_reg[0])
            begin
                byte_reg <= {byte_reg[6:0], 1'b0};
            end
            out_two_reg  <= two_ch;
            out_last_reg <= emit_last;
            if (op_reg == OP_SILENCE)
            begin
                out_run_reg    <= silence_reg;
                out_first_reg  <= SILENCE_BYTE;
                out_second_reg <= two_ch ? SILENCE_BYTE : 8'd0;
            end
            else
            begin
                out_run_reg    <= {{(RUN_W-DIVD_W){1'b0}}, quot_reg};
                out_first_reg  <= cur_byte;
                out_second_reg <= !two_ch ? 8'd0 :
                                  (mode_reg == MODE_INVERTED) ? inv_byte : cur_byte;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_second_reg, out_first_reg, out_run_reg};
    assign m_tuser  = out_two_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire
